// File: hdl/ahdlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_pkg: shared definitions for the async HDLC deframer
// Result codes, byte constants, the result record and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package ahdlc_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [12:0] MAX_FRAME = 13'd4096;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_GOOD      = 3'd1;
    localparam logic [2:0] KIND_BAD_CRC   = 3'd2;
    localparam logic [2:0] KIND_SHORT     = 3'd3;
    localparam logic [2:0] KIND_OVERFLOW  = 3'd4;
    localparam logic [2:0] KIND_DANGLING  = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [12:0] length;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/ahdlc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_in_stage: input register
// Captures one received byte per request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module ahdlc_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);
    import ahdlc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: hdl/ahdlc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_core: deframing state and per-byte logic
// Unescapes bytes, delays them through a two-byte hold, keeps the CRC and
// the counters, and forms at most one payload or verdict result for each byte.
// ----------------------------------------------------------------------------
module ahdlc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    input  logic               cfg_we,
    input  logic [12:0]        cfg_data,
    output logic               res_valid,
    output ahdlc_pkg::result_t res
);
    import ahdlc_pkg::*;

    logic [12:0] limit_reg;
    logic        esc_reg,  esc_next;
    logic [15:0] crc_reg,  crc_next;
    logic [1:0]  raw_reg,  raw_next;
    logic [12:0] cnt_reg,  cnt_next;
    logic        ovf_reg,  ovf_next;
    logic [7:0]  hold0_reg, hold0_next;
    logic [7:0]  hold1_reg, hold1_next;

    logic [12:0] eff_limit;
    logic [12:0] cnt_inc;
    logic [7:0]  b;
    logic        have_b;

    assign eff_limit = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
    assign cnt_inc   = cnt_reg + 13'd1;

    always_comb
    begin
        esc_next   = esc_reg;
        crc_next   = crc_reg;
        raw_next   = raw_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        res_valid  = 1'b0;
        res        = '0;
        b          = rx_byte;
        have_b     = 1'b0;

        if (rx_byte == FLAG_BYTE)
        begin
            res_valid = 1'b1;
            if (raw_reg != 2'd3)
            begin
                res.kind = KIND_SHORT;
            end
            else if (ovf_reg)
            begin
                res.kind = KIND_OVERFLOW;
            end
            else if (esc_reg)
            begin
                res.kind = KIND_DANGLING;
            end
            else if (~crc_reg == {hold1_reg, hold0_reg})
            begin
                res.kind   = KIND_GOOD;
                res.length = cnt_reg - 13'd2;
            end
            else
            begin
                res.kind = KIND_BAD_CRC;
            end
            esc_next = 1'b0;
            crc_next = CRC_SEED;
            raw_next = 2'd0;
            cnt_next = 13'd0;
            ovf_next = 1'b0;
        end
        else
        begin
            if (raw_reg != 2'd3)
            begin
                raw_next = raw_reg + 2'd1;
            end
            if (!ovf_reg)
            begin
                if (esc_reg)
                begin
                    b        = rx_byte ^ ESC_XOR;
                    esc_next = 1'b0;
                    have_b   = 1'b1;
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    have_b = 1'b1;
                end
            end
            if (have_b)
            begin
                cnt_next = cnt_inc;
                if (cnt_inc >= eff_limit)
                begin
                    ovf_next = 1'b1;
                end
                else if (cnt_inc > 13'd2)
                begin
                    res_valid   = 1'b1;
                    res.kind    = KIND_PAYLOAD;
                    res.payload = hold0_reg;
                    crc_next    = crc_byte(crc_reg, hold0_reg);
                    hold0_next  = hold1_reg;
                    hold1_next  = b;
                end
                else if (cnt_inc == 13'd1)
                begin
                    hold0_next = b;
                end
                else
                begin
                    hold1_next = b;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= MAX_FRAME;
            esc_reg   <= 1'b0;
            crc_reg   <= CRC_SEED;
            raw_reg   <= 2'd0;
            cnt_reg   <= 13'd0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (step)
            begin
                esc_reg <= esc_next;
                crc_reg <= crc_next;
                raw_reg <= raw_next;
                cnt_reg <= cnt_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
        end
    end

endmodule

// File: hdl/ahdlc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahdlc_out_reg: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ahdlc_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  ahdlc_pkg::result_t load_res,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output ahdlc_pkg::result_t out_res
);
    import ahdlc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// File: hdl/async_hdlc_deframer_crc16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// async_hdlc_deframer_crc16: async HDLC deframer with CRC-16/X-25 check
// Raw received bytes enter on the in channel, one per request. Each byte
// yields at most one request on the out channel: an unescaped payload byte
// (kind 0), or at the 0x7E flag a verdict: good with length, bad CRC, too
// short, overflow or dangling escape. Payload is streamed before its verdict,
// so the consumer must discard it unless the verdict is good.
// The byte is registered, processed combinationally in the core and registered
// again as a result; one byte is accepted every cycle while the consumer keeps
// up. When the consumer stalls, the result register holds and the input
// register fills; in_ready drops once both are full and returns when a result
// is taken. Reset clears all frame state, empties both registers and sets the
// limit to 4096. cfg_we writes the byte limit from cfg_data; the user must do
// so only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module async_hdlc_deframer_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic [7:0]  payload_byte,
    output logic [12:0] frame_length,
    input  logic        cfg_we,
    input  logic [12:0] cfg_data
);
    import ahdlc_pkg::*;

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       take;
    logic       out_free;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign take = s1_valid && out_free;

    ahdlc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .take       (take),
        .byte_valid (s1_valid),
        .byte_data  (s1_byte)
    );

    ahdlc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .rx_byte   (s1_byte),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    ahdlc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .load_res  (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign result_kind  = out_res.kind;
    assign payload_byte = out_res.payload;
    assign frame_length = out_res.length;

`ifndef NO_ASSERTIONS
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
        else $error("payload byte set on a verdict");

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != KIND_GOOD |-> frame_length == 13'd0)
        else $error("frame length set on a result that is not a good frame");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while both registers are full");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("stalled result changed");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the async HDLC deframer
// A short stimulus table opens the run, followed by random frames under
// several byte limits. Most frames are well formed with a valid X-25 FCS.
// The rest carry a flipped bit, a truncated or dangling-escape ending, or are
// noise. Every accepted byte goes through a deframing model in the bench.
// Each result request is compared field by field with the oldest expected
// result. Both sides idle at random outside one calm phase, and the consumer
// holds off once for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb;

    import ahdlc_pkg::*;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    verdict;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [12:0] frame_length;
    logic        cfg_we;
    logic [12:0] cfg_data;

    logic        esc_pend;
    logic [15:0] fcs_acc;
    logic [1:0]  raw_cnt;
    logic [12:0] byte_cnt;
    logic [7:0]  hold_lo;
    logic [7:0]  hold_hi;
    logic        ovf_seen;
    logic [12:0] limit_reg;

    result_t     pending_results[$];
    bit          row_typed;
    result_t     row_verdict;
    bit          calm;
    bit          hold_req;
    int          err_cnt;
    int          bytes_sent;
    int          phase_bytes;
    int          settings_used;
    int          kind_tally[6];

    dir_row_t dir_rows [0:23] = '{
        '{8'h7E, 1'b1, '{KIND_SHORT, 8'h00, 13'd0}},
        '{8'h31, 1'b0, '0}, '{8'h32, 1'b0, '0}, '{8'h33, 1'b0, '0},
        '{8'h34, 1'b0, '0}, '{8'h35, 1'b0, '0}, '{8'h36, 1'b0, '0},
        '{8'h37, 1'b0, '0}, '{8'h38, 1'b0, '0}, '{8'h39, 1'b0, '0},
        '{8'h6E, 1'b0, '0}, '{8'h90, 1'b0, '0},
        '{8'h7E, 1'b1, '{KIND_GOOD, 8'h00, 13'd9}},
        '{8'h41, 1'b0, '0}, '{8'h42, 1'b0, '0}, '{8'h7D, 1'b0, '0},
        '{8'h7E, 1'b1, '{KIND_DANGLING, 8'h00, 13'd0}},
        '{8'h7D, 1'b0, '0}, '{8'h5E, 1'b0, '0}, '{8'h7D, 1'b0, '0},
        '{8'h5D, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
        '{8'h7E, 1'b0, '0}
    };

    logic [12:0] phase_limits [0:8] = '{
        13'd8191, 13'd1, 13'd0, 13'd3, 13'd6, 13'd12, 13'd40, 13'd4096, 13'd2
    };

    async_hdlc_deframer_crc16 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] x25_fold(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] a;
        a = acc;
        for (int i = 0; i < 8; i++)
        begin
            a = (a[0] ^ d[i]) ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
        end
        return a;
    endfunction

    task automatic clear_frame();
        esc_pend = 1'b0;
        fcs_acc  = CRC_SEED;
        raw_cnt  = 2'd0;
        byte_cnt = 13'd0;
        ovf_seen = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] x, output bit got, output result_t res);
        logic [7:0]  b;
        logic [12:0] lim;
        got = 1'b0;
        res = '0;
        if (x == FLAG_BYTE)
        begin
            got = 1'b1;
            if (raw_cnt < 2'd3)
            begin
                res.kind = KIND_SHORT;
            end
            else if (ovf_seen)
            begin
                res.kind = KIND_OVERFLOW;
            end
            else if (esc_pend)
            begin
                res.kind = KIND_DANGLING;
            end
            else if (~fcs_acc == {hold_hi, hold_lo})
            begin
                res.kind   = KIND_GOOD;
                res.length = byte_cnt - 13'd2;
            end
            else
            begin
                res.kind = KIND_BAD_CRC;
            end
            clear_frame();
            return;
        end
        if (raw_cnt < 2'd3)
        begin
            raw_cnt = raw_cnt + 2'd1;
        end
        if (ovf_seen)
        begin
            return;
        end
        if (esc_pend)
        begin
            b = x ^ ESC_XOR;
            esc_pend = 1'b0;
        end
        else if (x == ESC_BYTE)
        begin
            esc_pend = 1'b1;
            return;
        end
        else
        begin
            b = x;
        end
        lim = (limit_reg > MAX_FRAME) ? MAX_FRAME : limit_reg;
        byte_cnt = byte_cnt + 13'd1;
        if (byte_cnt >= lim)
        begin
            ovf_seen = 1'b1;
            return;
        end
        if (byte_cnt > 13'd2)
        begin
            got = 1'b1;
            res.kind    = KIND_PAYLOAD;
            res.payload = hold_lo;
            fcs_acc = x25_fold(fcs_acc, hold_lo);
            hold_lo = hold_hi;
            hold_hi = b;
        end
        else if (byte_cnt == 13'd1)
        begin
            hold_lo = b;
        end
        else
        begin
            hold_hi = b;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        result_t res;
        bit      got;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: result_kind %0d payload_byte %02h frame_length %0d",
                       result_kind, payload_byte, frame_length);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                    err_cnt++;
                end
                if (payload_byte !== want.payload)
                begin
                    $error("payload_byte: expected %02h, actual %02h", want.payload,
                           payload_byte);
                    err_cnt++;
                end
                if (frame_length !== want.length)
                begin
                    $error("frame_length: expected %0d, actual %0d", want.length,
                           frame_length);
                    err_cnt++;
                end
                if (result_kind <= KIND_DANGLING)
                begin
                    kind_tally[result_kind]++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            deframe_byte(rx_byte, got, res);
            if (row_typed)
            begin
                got = 1'b1;
                res = row_verdict;
            end
            if (got)
            begin
                pending_results.push_back(res);
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (300)
                begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                end
            end
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t verdict);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 16)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid    <= 1'b1;
        rx_byte     <= b;
        row_typed   <= typed;
        row_verdict <= verdict;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        bytes_sent++;
        phase_bytes++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        int n;
        in_valid <= 1'b0;
        row_typed <= 1'b0;
        for (n = 0; n < 100000 && pending_results.size() != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (8)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [12:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        limit_reg = v;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int unsigned forced_len);
        logic [7:0]  body[$];
        logic [7:0]  wire_bytes[$];
        logic [7:0]  b;
        logic [15:0] acc;
        int unsigned len;
        int unsigned pick;
        int unsigned idx;
        pick = (forced_len != 0) ? 0 : $urandom_range(0, 99);
        if (forced_len != 0)
        begin
            len = forced_len;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            len = $urandom_range(17, 60);
        end
        else
        begin
            len = $urandom_range(0, 16);
        end
        if (pick >= 94)
        begin
            repeat ($urandom_range(0, 6))
            begin
                wire_bytes.push_back(($urandom_range(0, 3) == 0) ? pick_payload()
                                                                 : 8'($urandom));
            end
        end
        else
        begin
            acc = CRC_SEED;
            for (int i = 0; i < len; i++)
            begin
                b = pick_payload();
                body.push_back(b);
                acc = x25_fold(acc, b);
            end
            acc = ~acc;
            body.push_back(acc[7:0]);
            body.push_back(acc[15:8]);
            if (pick >= 70 && pick < 80)
            begin
                idx = $urandom_range(0, body.size() - 1);
                body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (pick >= 80 && pick < 87)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    body.delete(body.size() - 1);
                end
            end
            foreach (body[i])
            begin
                if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE ||
                    ($urandom_range(0, 9) == 0 && (body[i] ^ ESC_XOR) != FLAG_BYTE))
                begin
                    wire_bytes.push_back(ESC_BYTE);
                    wire_bytes.push_back(body[i] ^ ESC_XOR);
                end
                else
                begin
                    wire_bytes.push_back(body[i]);
                end
            end
            if (pick >= 87)
            begin
                wire_bytes.push_back(ESC_BYTE);
            end
        end
        wire_bytes.push_back(FLAG_BYTE);
        foreach (wire_bytes[i])
        begin
            send_byte(wire_bytes[i], 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        cfg_we      = 1'b0;
        cfg_data    = 13'd0;
        row_typed   = 1'b0;
        row_verdict = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        limit_reg   = 13'd4096;
        hold_lo     = 8'h00;
        hold_hi     = 8'h00;
        clear_frame();
        repeat (10)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        write_limit(13'd4096);
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].verdict);
        end
        wait_idle();

        foreach (phase_limits[p])
        begin
            write_limit(phase_limits[p]);
            calm = (p == 3);
            if (p == 7)
            begin
                hold_req = 1'b1;
            end
            phase_bytes = 0;
            while (phase_bytes < 110)
            begin
                send_frame(0);
            end
            wait_idle();
        end
        calm = 1'b0;

        repeat (20)
        begin
            @(posedge clk);
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            err_cnt++;
        end
        $display("Sent %0d raw bytes under %0d byte-limit settings; checked %0d payload bytes.",
                 bytes_sent, settings_used, kind_tally[KIND_PAYLOAD]);
        $display("Verdicts: %0d good, %0d bad CRC, %0d too short, %0d overflow, %0d dangling.",
                 kind_tally[KIND_GOOD], kind_tally[KIND_BAD_CRC], kind_tally[KIND_SHORT],
                 kind_tally[KIND_OVERFLOW], kind_tally[KIND_DANGLING]);
        if (err_cnt == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: async_hdlc_deframer_crc16.f
hdl/ahdlc_pkg.sv
hdl/ahdlc_in_stage.sv
hdl/ahdlc_core.sv
hdl/ahdlc_out_reg.sv
hdl/async_hdlc_deframer_crc16.sv
dv/tb.sv
